// ===== rtl/gcp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared types and constants of the greedy correlation pruner.
// ----------------------------------------------------------------------------
package gcp_pkg;

   localparam int MAX_VARS   = 64;
   localparam int IDX_BITS   = $clog2(MAX_VARS);
   localparam int NUM_BITS   = IDX_BITS + 1;
   localparam int VALUE_BITS = 16;
   localparam int MAG_BITS   = VALUE_BITS + 1;
   localparam int SUM_BITS   = MAG_BITS + IDX_BITS;
   localparam int ADDR_BITS  = 2 * IDX_BITS;
   localparam int CSR_BITS   = 16;

   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_PROTECT = 2'd1,
      MODE_RUN     = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_VIOLATION = 2'd1,
      STATUS_BAD_INDEX = 2'd2,
      STATUS_RSVD      = 2'd3
   } status_type;

   typedef enum logic {
      CSR_VARS_IN_USE = 1'b0,
      CSR_THRESHOLD   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                   mode;
      logic [IDX_BITS-1:0]          row_index;
      logic [IDX_BITS-1:0]          col_index;
      logic signed [VALUE_BITS-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] kept_index;
      logic                last;
      logic [1:0]          status;
   } rsp_type;

   // Magnitude of a two's complement entry; the most negative value maps to 2^(VALUE_BITS-1).
   function automatic logic [MAG_BITS-1:0] magnitude(input logic [VALUE_BITS-1:0] v);
      logic [MAG_BITS-1:0] ext;
      begin
         ext = {v[VALUE_BITS-1], v};
         magnitude = v[VALUE_BITS-1] ? (~ext + MAG_BITS'(1)) : ext;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/greedy_correlation_pruner_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_correlation_pruner_unit
// Greedy removal of strongly associated variables from a square matrix.
// ----------------------------------------------------------------------------
// Load items (entry write, protect) are taken on the req_ channel at one per
// cycle while the block is idle and give no result. A run item makes the
// block busy; req_ready stays low until the run has loaded its last result
// into the output register. The run repeats rounds; each round walks every
// row i of the n variables in use and reads two matrix entries per column
// through the two read ports of the matrix memory. At most n rounds happen;
// then the survivors are listed, one per result. Results leave through an
// output register on the rsp_ channel; when the receiver stalls, the block
// holds that result and waits. An error run gives one result with last set.
// Reset clears the protected set, the sticky bad-index flag and the registers
// to their defaults; the matrix is not cleared and must be written before
// use. The csr_ port writes vars_in_use and assoc_threshold; the user must
// do so only while the block is idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module greedy_correlation_pruner_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire gcp_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output gcp_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [gcp_pkg::CSR_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINAL, ST_ROUND_END, ST_EMIT, ST_ERR
   } state_type;

   state_type state_ff;

   logic [gcp_pkg::VALUE_BITS-1:0] mem [gcp_pkg::MAX_VARS*gcp_pkg::MAX_VARS];
   logic [gcp_pkg::VALUE_BITS-1:0] rd_a_ff, rd_b_ff;
   logic [gcp_pkg::ADDR_BITS-1:0]  addr_a, addr_b;

   logic [gcp_pkg::NUM_BITS-1:0]   vars_ff;
   logic [gcp_pkg::VALUE_BITS-1:0] thr_ff;
   logic [gcp_pkg::MAX_VARS-1:0]   active_ff, protected_ff;
   logic                           bad_flag_ff;
   logic [gcp_pkg::IDX_BITS-1:0]   i_ff, j_ff;
   logic                           pv_ff;
   logic [gcp_pkg::NUM_BITS-1:0]   cnt_ff;
   logic [gcp_pkg::MAG_BITS-1:0]   max_ff;
   logic [gcp_pkg::SUM_BITS-1:0]   sum_ff;
   logic                           any_ff, found_ff;
   logic [gcp_pkg::NUM_BITS-1:0]   best_cnt_ff;
   logic [gcp_pkg::MAG_BITS-1:0]   best_max_ff;
   logic [gcp_pkg::SUM_BITS-1:0]   best_sum_ff;
   logic [gcp_pkg::IDX_BITS-1:0]   best_idx_ff;
   logic [1:0]                     err_status_ff;
   logic                           rsp_valid_ff;
   gcp_pkg::rsp_type               rsp_ff;

   logic [gcp_pkg::NUM_BITS-1:0]   n_used;
   logic [gcp_pkg::MAX_VARS-1:0]   mask_n, higher;
   logic                           run_error, last_j, slot_free, req_acc;
   logic [gcp_pkg::MAG_BITS-1:0]   mag_a, mag_b;
   logic                           cand, better, no_more, rsp_load;

   always_comb begin
      if (vars_ff == '0) begin
         n_used = gcp_pkg::NUM_BITS'(1);
      end else if (vars_ff > gcp_pkg::NUM_BITS'(gcp_pkg::MAX_VARS)) begin
         n_used = gcp_pkg::NUM_BITS'(gcp_pkg::MAX_VARS);
      end else begin
         n_used = vars_ff;
      end
      if (n_used == gcp_pkg::NUM_BITS'(gcp_pkg::MAX_VARS)) begin
         mask_n = '1;
      end else begin
         mask_n = (gcp_pkg::MAX_VARS'(1) << n_used) - gcp_pkg::MAX_VARS'(1);
      end
      run_error = bad_flag_ff || ((protected_ff & ~mask_n) != '0);
      last_j    = ({1'b0, j_ff} == (n_used - gcp_pkg::NUM_BITS'(1)));
      addr_a    = {i_ff, j_ff};
      addr_b    = (i_ff < j_ff) ? {i_ff, j_ff} : {j_ff, i_ff};
      mag_a     = gcp_pkg::magnitude(rd_a_ff);
      mag_b     = gcp_pkg::magnitude(rd_b_ff);
      cand      = active_ff[i_ff] && (cnt_ff != '0) && !protected_ff[i_ff];
      better    = !found_ff || (cnt_ff > best_cnt_ff) ||
                  ((cnt_ff == best_cnt_ff) && ((max_ff > best_max_ff) ||
                   ((max_ff == best_max_ff) && (sum_ff > best_sum_ff))));
      higher    = active_ff & ~((gcp_pkg::MAX_VARS'(2) << i_ff) - gcp_pkg::MAX_VARS'(1));
      no_more   = (higher == '0);
      slot_free = !rsp_valid_ff || rsp_ready;
      req_acc   = req_valid && req_ready;
      rsp_load  = slot_free && (((state_ff == ST_EMIT) && active_ff[i_ff]) ||
                  (state_ff == ST_ERR));
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (req_acc && (req_data.mode == gcp_pkg::MODE_WRITE)) begin
         mem[{req_data.row_index, req_data.col_index}] <= req_data.entry_value;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vars_ff       <= gcp_pkg::NUM_BITS'(gcp_pkg::MAX_VARS);
         thr_ff        <= gcp_pkg::VALUE_BITS'(29491);
         active_ff     <= '1;
         protected_ff  <= '0;
         bad_flag_ff   <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         pv_ff         <= 1'b0;
         cnt_ff        <= '0;
         max_ff        <= '0;
         sum_ff        <= '0;
         any_ff        <= 1'b0;
         found_ff      <= 1'b0;
         best_cnt_ff   <= '0;
         best_max_ff   <= '0;
         best_sum_ff   <= '0;
         best_idx_ff   <= '0;
         err_status_ff <= gcp_pkg::STATUS_OK;
         rsp_valid_ff  <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               gcp_pkg::CSR_VARS_IN_USE: vars_ff <= csr_wdata[gcp_pkg::NUM_BITS-1:0];
               gcp_pkg::CSR_THRESHOLD:   thr_ff  <= csr_wdata[gcp_pkg::VALUE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         pv_ff <= (state_ff == ST_SCAN) && active_ff[j_ff] && (j_ff != i_ff);
         if (pv_ff) begin
            if (mag_b > {1'b0, thr_ff}) begin
               cnt_ff <= cnt_ff + gcp_pkg::NUM_BITS'(1);
            end
            if (mag_a > max_ff) begin
               max_ff <= mag_a;
            end
            sum_ff <= sum_ff + gcp_pkg::SUM_BITS'(mag_a);
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  unique case (req_data.mode)
                     gcp_pkg::MODE_PROTECT: begin
                        if ({1'b0, req_data.row_index} >= n_used) begin
                           bad_flag_ff <= 1'b1;
                        end else begin
                           protected_ff[req_data.row_index] <= 1'b1;
                        end
                     end
                     gcp_pkg::MODE_RUN: begin
                        i_ff     <= '0;
                        j_ff     <= '0;
                        cnt_ff   <= '0;
                        max_ff   <= '0;
                        sum_ff   <= '0;
                        any_ff   <= 1'b0;
                        found_ff <= 1'b0;
                        if (run_error) begin
                           err_status_ff <= gcp_pkg::STATUS_BAD_INDEX;
                           state_ff      <= ST_ERR;
                        end else begin
                           active_ff <= mask_n;
                           state_ff  <= ST_SCAN;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               j_ff <= j_ff + gcp_pkg::IDX_BITS'(1);
               if (last_j) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINAL;
            end
            ST_FINAL: begin
               if (active_ff[i_ff] && (cnt_ff != '0)) begin
                  any_ff <= 1'b1;
               end
               if (cand && better) begin
                  found_ff    <= 1'b1;
                  best_cnt_ff <= cnt_ff;
                  best_max_ff <= max_ff;
                  best_sum_ff <= sum_ff;
                  best_idx_ff <= i_ff;
               end
               cnt_ff <= '0;
               max_ff <= '0;
               sum_ff <= '0;
               j_ff   <= '0;
               if ({1'b0, i_ff} == (n_used - gcp_pkg::NUM_BITS'(1))) begin
                  state_ff <= ST_ROUND_END;
               end else begin
                  i_ff     <= i_ff + gcp_pkg::IDX_BITS'(1);
                  state_ff <= ST_SCAN;
               end
            end
            ST_ROUND_END: begin
               i_ff     <= '0;
               j_ff     <= '0;
               any_ff   <= 1'b0;
               found_ff <= 1'b0;
               if (!any_ff) begin
                  state_ff <= ST_EMIT;
               end else if (!found_ff) begin
                  err_status_ff <= gcp_pkg::STATUS_VIOLATION;
                  state_ff      <= ST_ERR;
               end else begin
                  active_ff[best_idx_ff] <= 1'b0;
                  state_ff               <= ST_SCAN;
               end
            end
            ST_EMIT: begin
               if (!active_ff[i_ff]) begin
                  i_ff <= i_ff + gcp_pkg::IDX_BITS'(1);
               end else if (slot_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.kept_index  <= i_ff;
                  rsp_ff.last        <= no_more;
                  rsp_ff.status      <= gcp_pkg::STATUS_OK;
                  i_ff               <= i_ff + gcp_pkg::IDX_BITS'(1);
                  if (no_more) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_ERR: begin
               if (slot_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.kept_index <= '0;
                  rsp_ff.last       <= 1'b1;
                  rsp_ff.status     <= err_status_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ({1'b0, j_ff} < n_used) && ({1'b0, i_ff} < n_used))
      else $error("scan index beyond the variables in use");

   a_scan_active_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((active_ff & ~mask_n) == '0))
      else $error("active variable beyond the variables in use");

   a_no_protected_removal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND_END) && any_ff && found_ff |-> !protected_ff[best_idx_ff])
      else $error("protected variable chosen for removal");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != gcp_pkg::STATUS_OK) |-> rsp_ff.last)
      else $error("error item without last");

   a_emit_survivor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && active_ff[i_ff] && slot_free |=>
      rsp_valid_ff && (rsp_ff.status == gcp_pkg::STATUS_OK))
      else $error("survivor not presented");

endmodule
`default_nettype wire
